// ===== hdl/erle_pkg.sv =====
// types and constants shared by the escape-byte run-length encoder
// no dependencies

package erle_pkg;

    localparam logic [7:0] RUN_MAX         = 8'd255;
    localparam logic [7:0] MIN_ESCAPED_RUN = 8'd4;
    localparam logic [7:0] ESCAPE_BYTE     = 8'd0;
    localparam int         GROUP_BYTES     = 6;
    localparam int         GROUP_CNT_W     = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_beat_t;

    // one emitted run: up to three bytes
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
    } run_emit_t;

    // every output byte caused by one input beat
    typedef struct packed {
        logic [GROUP_BYTES-1:0][7:0] bytes;
        logic [GROUP_CNT_W-1:0]      count;
        logic                        last;
    } group_t;

endpackage

// ===== hdl/erle_core.sv =====
// input register, run state and per-beat encoding into a byte group
// depends on erle_pkg

module erle_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  erle_pkg::in_beat_t s_data,
    output logic              grp_valid,
    input  logic              grp_ready,
    output erle_pkg::group_t  grp_data
);
    import erle_pkg::*;

    in_beat_t   in_reg;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] run_value_reg, run_value_next;
    logic [7:0] run_length_reg, run_length_next;
    logic       run_open_reg, run_open_next;

    logic       s_accept, consume;
    logic [7:0] cur_byte, len_inc, mid_value, mid_length;
    logic       match, mid_open;
    run_emit_t  emit_a, emit_b;
    group_t     grp;

    function automatic run_emit_t emit_run(input logic [7:0] value, input logic [7:0] len);
        run_emit_t r;
        if (len >= MIN_ESCAPED_RUN || value == ESCAPE_BYTE) begin
            r.bytes[0] = ESCAPE_BYTE;
            r.bytes[1] = value;
            r.bytes[2] = len;
            r.count    = 2'd3;
        end else begin
            r.bytes[0] = value;
            r.bytes[1] = value;
            r.bytes[2] = value;
            r.count    = len[1:0];
        end
        return r;
    endfunction

    assign s_ready  = !in_valid_reg || grp_ready;
    assign s_accept = s_valid && s_ready;
    assign consume  = in_valid_reg && grp_ready;
    assign cur_byte = in_reg.in_byte;
    assign match    = run_open_reg && (cur_byte == run_value_reg);
    assign len_inc  = run_length_reg + 8'd1;

    always_comb begin
        emit_a          = '0;
        emit_b          = '0;
        mid_value       = run_value_reg;
        mid_length      = run_length_reg;
        mid_open        = run_open_reg;
        if (match) begin
            if (len_inc == RUN_MAX) begin
                // full run goes out at once
                emit_a.bytes[0] = ESCAPE_BYTE;
                emit_a.bytes[1] = run_value_reg;
                emit_a.bytes[2] = RUN_MAX;
                emit_a.count    = 2'd3;
                mid_open        = 1'b0;
                mid_length      = 8'd1;
            end else begin
                mid_length = len_inc;
            end
        end else begin
            if (run_open_reg) begin
                emit_a = emit_run(run_value_reg, run_length_reg);
            end
            mid_value  = cur_byte;
            mid_length = 8'd1;
            mid_open   = 1'b1;
        end
        run_value_next  = mid_value;
        run_length_next = mid_length;
        run_open_next   = mid_open;
        if (in_reg.in_last && mid_open) begin
            emit_b          = emit_run(mid_value, mid_length);
            run_open_next   = 1'b0;
            run_length_next = 8'd1;
        end
    end

    // pack the two emitted runs back to back
    always_comb begin
        grp       = '0;
        grp.count = GROUP_CNT_W'(emit_a.count) + GROUP_CNT_W'(emit_b.count);
        grp.last  = in_reg.in_last;
        case (emit_a.count)
            2'd0: begin
                grp.bytes[2:0] = emit_b.bytes;
            end
            2'd1: begin
                grp.bytes[0]   = emit_a.bytes[0];
                grp.bytes[3:1] = emit_b.bytes;
            end
            2'd2: begin
                grp.bytes[1:0] = emit_a.bytes[1:0];
                grp.bytes[4:2] = emit_b.bytes;
            end
            default: begin
                grp.bytes[2:0] = emit_a.bytes;
                grp.bytes[5:3] = emit_b.bytes;
            end
        endcase
    end

    assign grp_data  = grp;
    assign grp_valid = in_valid_reg && (grp.count != '0);

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            run_value_reg  <= 8'd0;
            run_length_reg <= 8'd1;
            run_open_reg   <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (consume) begin
                run_value_reg  <= run_value_next;
                run_length_reg <= run_length_next;
                run_open_reg   <= run_open_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg <= s_data;
        end
    end

endmodule

// ===== hdl/erle_group_fifo.sv =====
// queue of byte groups between the encoder and the output serialiser
// depends on erle_pkg

module erle_group_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  erle_pkg::group_t wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output erle_pkg::group_t rd_data
);
    import erle_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    group_t        mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/erle_serialiser.sv =====
// holds one byte group and sends its bytes one beat at a time
// depends on erle_pkg

module erle_serialiser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               grp_valid,
    output logic               grp_ready,
    input  erle_pkg::group_t   grp_data,
    output logic               m_valid,
    input  logic               m_ready,
    output erle_pkg::out_beat_t m_data
);
    import erle_pkg::*;

    group_t                 cur_reg;
    logic                   cur_valid_reg;
    logic [GROUP_CNT_W-1:0] idx_reg;
    logic                   last_byte, done, load;

    assign m_valid   = cur_valid_reg;
    assign last_byte = (idx_reg == cur_reg.count - GROUP_CNT_W'(1));
    assign done      = m_valid && m_ready && last_byte;
    // take the next group in the cycle the current one finishes
    assign load      = !cur_valid_reg || done;
    assign grp_ready = load;

    assign m_data.out_byte = cur_reg.bytes[idx_reg];
    assign m_data.out_last = cur_reg.last && last_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (load) begin
            cur_valid_reg <= grp_valid;
            idx_reg       <= '0;
        end else if (m_valid && m_ready) begin
            idx_reg <= idx_reg + GROUP_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load && grp_valid) begin
            cur_reg <= grp_data;
        end
    end

endmodule

// ===== hdl/escape_rle_byte_encoder.sv =====
// escape-byte run-length encoder, one input byte per beat
// path: input register, group queue, then serialiser register
// throughput: one input beat per cycle while the group queue has room,
// output one byte per cycle; the output port sets the sustained rate
// reset: synchronous active-low aresetn empties all stages, no run open
// depends on erle_pkg, erle_core, erle_group_fifo, erle_serialiser

module escape_rle_byte_encoder #(
    parameter int GROUP_DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  erle_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output erle_pkg::out_beat_t m_data
);
    import erle_pkg::*;

    group_t enc_grp, q_grp;
    logic   enc_valid, enc_ready, q_valid, q_ready;

    erle_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .grp_valid (enc_valid),
        .grp_ready (enc_ready),
        .grp_data  (enc_grp)
    );

    erle_group_fifo #(
        .DEPTH (GROUP_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (enc_valid),
        .wr_ready (enc_ready),
        .wr_data  (enc_grp),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_grp)
    );

    erle_serialiser u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .grp_valid (q_valid),
        .grp_ready (q_ready),
        .grp_data  (q_grp),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
